### rtl/gbd_pkg.sv
package gbd_pkg;

  localparam int SIZE_BITS = 24;
  localparam int ANGLE_BITS = 16;

  localparam int DW = 64;
  localparam int ZW = 34;
  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS = 32;

  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = (SIZE_BITS > ANGLE_BITS) ? SIZE_BITS : ANGLE_BITS;

  localparam logic [29:0] K_Q30 = 30'd652032874;
  localparam logic [29:0] K2_Q30 = 30'd395948878;

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
    32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  typedef enum logic [1:0] {
    OUTCOME_RESOLVED = 2'd0,
    OUTCOME_POINT    = 2'd1,
    OUTCOME_FAIL     = 2'd2
  } outcome_t;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_BEAM_MAJOR = 2'd0,
    CFG_BEAM_MINOR = 2'd1,
    CFG_BEAM_ANGLE = 2'd2
  } cfg_addr_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0]         source_major;
    logic [SIZE_BITS-1:0]         source_minor;
    logic signed [ANGLE_BITS-1:0] source_angle;
  } in_item_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0]         result_major;
    logic [SIZE_BITS-1:0]         result_minor;
    logic signed [ANGLE_BITS-1:0] result_angle;
    outcome_t                     outcome;
  } out_item_t;

endpackage

### rtl/gbd_cordic_stage.sv
module gbd_cordic_stage #(
  parameter int IDX = 0,
  parameter bit VEC = 1'b0,
  parameter int TW = 1
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [gbd_pkg::DW-1:0] x_i,
  input  logic signed [gbd_pkg::DW-1:0] y_i,
  input  logic signed [gbd_pkg::ZW-1:0] z_i,
  input  logic [TW-1:0]                 tag_i,
  output logic signed [gbd_pkg::DW-1:0] x_o,
  output logic signed [gbd_pkg::DW-1:0] y_o,
  output logic signed [gbd_pkg::ZW-1:0] z_o,
  output logic [TW-1:0]                 tag_o
);

  localparam logic signed [gbd_pkg::ZW-1:0] ANG = gbd_pkg::ZW'(gbd_pkg::ATAN_TURNS[IDX]);

  logic signed [gbd_pkg::DW-1:0] xs, ys;
  logic signed [gbd_pkg::DW-1:0] x_r, y_r;
  logic signed [gbd_pkg::ZW-1:0] z_r;
  logic [TW-1:0]                 tag_r;
  logic                          ccw;

  assign xs = x_i >>> IDX;
  assign ys = y_i >>> IDX;
  // rotation steers on the residual angle, vectoring on the sign of y
  assign ccw = VEC ? (y_i <= 0) : (z_i >= 0);

  always_ff @(posedge clk) begin
    if (en) begin
      if (ccw) begin
        x_r <= x_i - ys;
        y_r <= y_i + xs;
        z_r <= z_i - ANG;
      end else begin
        x_r <= x_i + ys;
        y_r <= y_i - xs;
        z_r <= z_i + ANG;
      end
      tag_r <= tag_i;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;
  assign tag_o = tag_r;

endmodule

### rtl/gbd_isqrt_stage.sv
module gbd_isqrt_stage #(
  parameter int IDX = 0,
  parameter int TW = 1
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [gbd_pkg::DW-1:0] n_i,
  input  logic [gbd_pkg::DW-1:0] r_i,
  input  logic [TW-1:0]          tag_i,
  output logic [gbd_pkg::DW-1:0] n_o,
  output logic [gbd_pkg::DW-1:0] r_o,
  output logic [TW-1:0]          tag_o
);

  localparam logic [gbd_pkg::DW-1:0] SQ_BIT = gbd_pkg::DW'(1) << (62 - 2 * IDX);

  logic [gbd_pkg::DW-1:0] trial;
  logic [gbd_pkg::DW-1:0] n_r, r_r;
  logic [TW-1:0]          tag_r;

  assign trial = r_i + SQ_BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (n_i >= trial) begin
        n_r <= n_i - trial;
        r_r <= (r_i >> 1) + SQ_BIT;
      end else begin
        n_r <= n_i;
        r_r <= r_i >> 1;
      end
      tag_r <= tag_i;
    end
  end

  assign n_o = n_r;
  assign r_o = r_r;
  assign tag_o = tag_r;

endmodule

### rtl/gaussian_beam_deconvolver_unit.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | in_data  (gbd_pkg::in_item_t)
// out     | output    | out_valid / out_ready| out_data (gbd_pkg::out_item_t)
// cfg     | input     | cfg_valid / cfg_ready| cfg_addr, cfg_data
//
// One transfer per cycle in and out while out is not stalled; the pipeline holds the two
// 30-step CORDIC chains and the 32-step square-root chain.
// rst_n is synchronous; it clears valid bits and loads the beam registers.
// A stall on out holds every stage at once; in_ready drops in the same cycle.
// cfg_ready is always high; write only while the pipeline is empty.
module gaussian_beam_deconvolver_unit #(
  parameter int SIZE_BITS = gbd_pkg::SIZE_BITS,
  parameter int ANGLE_BITS = gbd_pkg::ANGLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  gbd_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gbd_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gbd_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [gbd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int DW = gbd_pkg::DW;
  localparam int ZW = gbd_pkg::ZW;
  localparam int NR = gbd_pkg::CORDIC_STEPS;
  localparam int NQ = gbd_pkg::SQRT_STEPS;
  localparam int SQ_SHIFT = 56 - 2 * SIZE_BITS;
  localparam int SQ_L = (SQ_SHIFT >= 0) ? SQ_SHIFT : 0;
  localparam int SQ_R = (SQ_SHIFT < 0) ? -SQ_SHIFT : 0;
  localparam int E = 30 - SIZE_BITS;
  localparam int EL = (E >= 1) ? E : 0;
  localparam int EM1 = (E >= 1) ? E - 1 : 0;
  localparam int XL = (E < 0) ? -2 * E : 0;
  localparam int ANG_SH = 33 - ANGLE_BITS;
  localparam int VTW = 3 * DW + 1;
  localparam logic signed [ANGLE_BITS:0] QTR = (ANGLE_BITS + 1)'(1) << (ANGLE_BITS - 2);
  localparam logic signed [ANGLE_BITS:0] HALF = (ANGLE_BITS + 1)'(1) << (ANGLE_BITS - 1);
  localparam logic [ANGLE_BITS-1:0] PA_QTR = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [ANGLE_BITS-1:0] PA_NQTR = ~PA_QTR + ANGLE_BITS'(1);
  localparam logic [32:0] SIZE_MAX = (33'd1 << SIZE_BITS) - 33'd1;

  function automatic logic signed [DW-1:0] sq_scaled(input logic [SIZE_BITS-1:0] a);
    logic [2*SIZE_BITS-1:0] p;
    p = a * a;
    return (DW'(p) << SQ_L) >> SQ_R;
  endfunction

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign cfg_ready = 1'b1;

  // beam registers
  logic [SIZE_BITS-1:0]  beam_major_r, beam_minor_r;
  logic [ANGLE_BITS-1:0] beam_angle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_major_r <= SIZE_BITS'(1);
      beam_minor_r <= SIZE_BITS'(1);
      beam_angle_r <= '0;
    end else if (cfg_valid) begin
      case (gbd_pkg::cfg_addr_t'(cfg_addr))
        gbd_pkg::CFG_BEAM_MAJOR: beam_major_r <= cfg_data[SIZE_BITS-1:0];
        gbd_pkg::CFG_BEAM_MINOR: beam_minor_r <= cfg_data[SIZE_BITS-1:0];
        gbd_pkg::CFG_BEAM_ANGLE: beam_angle_r <= cfg_data[ANGLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // valid bits
  logic v0_r, v1_r, v2_r, v3_r, vf_r, v4_r, v5_r, v6_r, v7_r, v8_r, out_valid_r;
  logic [NR-1:0] rot_v_r, vec_v_r;
  logic [NQ-1:0] sq_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0; v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; vf_r <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0;
      rot_v_r <= '0;
      vec_v_r <= '0;
      sq_v_r <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      rot_v_r <= {rot_v_r[NR-2:0], v2_r};
      v3_r <= rot_v_r[NR-1];
      vf_r <= v3_r;
      vec_v_r <= {vec_v_r[NR-2:0], vf_r};
      v4_r <= vec_v_r[NR-1];
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
      sq_v_r <= {sq_v_r[NQ-2:0], v8_r};
      out_valid_r <= sq_v_r[NQ-1];
    end
  end

  assign out_valid = out_valid_r;

  // stage 0: capture, smallest axis
  logic [SIZE_BITS-1:0]  sa0_r, sb0_r, m0_r, m_src, m_beam, m_nxt;
  logic [ANGLE_BITS-1:0] sang0_r;

  assign m_src = (in_data.source_minor < in_data.source_major) ?
                 in_data.source_minor : in_data.source_major;
  assign m_beam = (beam_minor_r < beam_major_r) ? beam_minor_r : beam_major_r;
  assign m_nxt = (m_beam < m_src) ? m_beam : m_src;

  always_ff @(posedge clk) begin
    if (en) begin
      sa0_r <= in_data.source_major;
      sb0_r <= in_data.source_minor;
      sang0_r <= in_data.source_angle;
      m0_r <= m_nxt;
    end
  end

  // stage 1: squares, doubled angles as turns
  logic signed [DW-1:0] as1_r, bs1_r, ab1_r, bb1_r, lim1_r;
  logic [31:0]          us1_r, ub1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      as1_r <= sq_scaled(sa0_r);
      bs1_r <= sq_scaled(sb0_r);
      ab1_r <= sq_scaled(beam_major_r);
      bb1_r <= sq_scaled(beam_minor_r);
      lim1_r <= sq_scaled(m0_r);
      us1_r <= {sang0_r[ANGLE_BITS-2:0], {ANG_SH{1'b0}}};
      ub1_r <= {beam_angle_r[ANGLE_BITS-2:0], {ANG_SH{1'b0}}};
    end
  end

  // stage 2: axis differences, fold into the CORDIC range
  logic signed [DW-1:0] ds_nxt, db_nxt;
  logic [31:0]          ups, upb, us_f, ub_f;
  logic signed [DW-1:0] s2_r, lim2_r, x0s_r, x0b_r;
  logic signed [ZW-1:0] z0s_r, z0b_r;

  assign ds_nxt = as1_r - bs1_r;
  assign db_nxt = ab1_r - bb1_r;
  assign ups = us1_r + 32'h4000_0000;
  assign upb = ub1_r + 32'h4000_0000;
  assign us_f = {us1_r[31] ^ ups[31], us1_r[30:0]};
  assign ub_f = {ub1_r[31] ^ upb[31], ub1_r[30:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= (as1_r + bs1_r) - (ab1_r + bb1_r);
      lim2_r <= lim1_r;
      x0s_r <= ups[31] ? -ds_nxt : ds_nxt;
      x0b_r <= upb[31] ? -db_nxt : db_nxt;
      z0s_r <= ZW'($signed(us_f));
      z0b_r <= ZW'($signed(ub_f));
    end
  end

  // rotation chains
  logic signed [DW-1:0] rsx [0:NR];
  logic signed [DW-1:0] rsy [0:NR];
  logic signed [ZW-1:0] rsz [0:NR];
  logic [DW-1:0]        rst_s [0:NR];
  logic signed [DW-1:0] rbx [0:NR];
  logic signed [DW-1:0] rby [0:NR];
  logic signed [ZW-1:0] rbz [0:NR];
  logic [DW-1:0]        rbt_l [0:NR];

  assign rsx[0] = x0s_r;
  assign rsy[0] = '0;
  assign rsz[0] = z0s_r;
  assign rst_s[0] = s2_r;
  assign rbx[0] = x0b_r;
  assign rby[0] = '0;
  assign rbz[0] = z0b_r;
  assign rbt_l[0] = lim2_r;

  for (genvar k = 0; k < NR; k++) begin : g_rot
    gbd_cordic_stage #(.IDX(k), .VEC(1'b0), .TW(DW)) u_src (
      .clk(clk), .en(en),
      .x_i(rsx[k]), .y_i(rsy[k]), .z_i(rsz[k]), .tag_i(rst_s[k]),
      .x_o(rsx[k+1]), .y_o(rsy[k+1]), .z_o(rsz[k+1]), .tag_o(rst_s[k+1])
    );
    gbd_cordic_stage #(.IDX(k), .VEC(1'b0), .TW(DW)) u_beam (
      .clk(clk), .en(en),
      .x_i(rbx[k]), .y_i(rby[k]), .z_i(rbz[k]), .tag_i(rbt_l[k]),
      .x_o(rbx[k+1]), .y_o(rby[k+1]), .z_o(rbz[k+1]), .tag_o(rbt_l[k+1])
    );
  end

  // stage 3: difference vector
  logic signed [DW-1:0] vx3_r, vy3_r, s3_r, lim3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      vx3_r <= rsx[NR] - rbx[NR];
      vy3_r <= rsy[NR] - rby[NR];
      s3_r <= rst_s[NR];
      lim3_r <= rbt_l[NR];
    end
  end

  // fold stage: vectoring starts in the right half plane
  logic signed [DW-1:0] fx_r, fy_r;
  logic signed [ZW-1:0] fz_r;
  logic [VTW-1:0]       ft_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (vx3_r < 0) begin
        fx_r <= -vx3_r;
        fy_r <= -vy3_r;
        fz_r <= ZW'(33'sh0_8000_0000);
      end else begin
        fx_r <= vx3_r;
        fy_r <= vy3_r;
        fz_r <= '0;
      end
      ft_r <= {s3_r, lim3_r, vx3_r, (vx3_r != 0) || (vy3_r != 0)};
    end
  end

  // vectoring chain
  logic signed [DW-1:0] vcx [0:NR];
  logic signed [DW-1:0] vcy [0:NR];
  logic signed [ZW-1:0] vcz [0:NR];
  logic [VTW-1:0]       vct [0:NR];

  assign vcx[0] = fx_r;
  assign vcy[0] = fy_r;
  assign vcz[0] = fz_r;
  assign vct[0] = ft_r;

  for (genvar k = 0; k < NR; k++) begin : g_vec
    gbd_cordic_stage #(.IDX(k), .VEC(1'b1), .TW(VTW)) u_vec (
      .clk(clk), .en(en),
      .x_i(vcx[k]), .y_i(vcy[k]), .z_i(vcz[k]), .tag_i(vct[k]),
      .x_o(vcx[k+1]), .y_o(vcy[k+1]), .z_o(vcz[k+1]), .tag_o(vct[k+1])
    );
  end

  // stage 4: magnitudes, output angle
  logic signed [DW-1:0] s_v, lim_v, vx_v;
  logic                 nz_v;
  logic signed [32:0]   pz;
  logic signed [32:0]   pa_full;
  logic [ANGLE_BITS-1:0] pa_nxt;
  logic [DW-1:0]        mag4_r, cxa4_r;
  logic                 magn4_r, cxn4_r;
  logic signed [DW-1:0] s4_r, lim4_r;
  logic [ANGLE_BITS-1:0] pa4_r;

  assign {s_v, lim_v, vx_v, nz_v} = vct[NR];
  assign pz = 33'($signed(vcz[NR][31:0])) + (33'sd1 <<< (32 - ANGLE_BITS));
  assign pa_full = pz >>> ANG_SH;

  always_comb begin
    pa_nxt = pa_full[ANGLE_BITS-1:0];
    if (!nz_v) begin
      pa_nxt = '0;
    end else if (pa_nxt == PA_NQTR) begin
      pa_nxt = PA_QTR;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      magn4_r <= vcx[NR][DW-1];
      mag4_r <= vcx[NR][DW-1] ? DW'(-vcx[NR]) : DW'(vcx[NR]);
      cxn4_r <= vx_v[DW-1];
      cxa4_r <= vx_v[DW-1] ? DW'(-vx_v) : DW'(vx_v);
      s4_r <= s_v;
      lim4_r <= lim_v;
      pa4_r <= pa_nxt;
    end
  end

  // stage 5: gain correction partial products
  logic [DW-1:0]        th5_r, ch5_r;
  logic [59:0]          tl5_r, cl5_r;
  logic                 magn5_r, cxn5_r;
  logic signed [DW-1:0] s5_r, lim5_r;
  logic [ANGLE_BITS-1:0] pa5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      th5_r <= mag4_r[DW-1:30] * gbd_pkg::K2_Q30;
      tl5_r <= mag4_r[29:0] * gbd_pkg::K2_Q30;
      ch5_r <= cxa4_r[DW-1:30] * gbd_pkg::K_Q30;
      cl5_r <= cxa4_r[29:0] * gbd_pkg::K_Q30;
      magn5_r <= magn4_r;
      cxn5_r <= cxn4_r;
      s5_r <= s4_r;
      lim5_r <= lim4_r;
      pa5_r <= pa4_r;
    end
  end

  // stage 6: t and the gain-corrected x
  logic [DW-1:0]        tr_nxt, cr_nxt;
  logic signed [DW-1:0] t6_r, cx6_r, s6_r, lim6_r;
  logic [ANGLE_BITS-1:0] pa6_r;

  assign tr_nxt = th5_r + DW'(tl5_r >> 30);
  assign cr_nxt = ch5_r + DW'(cl5_r >> 30);

  always_ff @(posedge clk) begin
    if (en) begin
      t6_r <= magn5_r ? -$signed(tr_nxt) : $signed(tr_nxt);
      cx6_r <= cxn5_r ? -$signed(cr_nxt) : $signed(cr_nxt);
      s6_r <= s5_r;
      lim6_r <= lim5_r;
      pa6_r <= pa5_r;
    end
  end

  // stage 7: sums
  logic signed [DW-1:0] ta7_r, tb7_r, dmt7_r, spt7_r, lim7_r;
  logic [ANGLE_BITS-1:0] pa7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ta7_r <= s6_r + cx6_r;
      tb7_r <= s6_r - cx6_r;
      dmt7_r <= s6_r - t6_r;
      spt7_r <= s6_r + t6_r;
      lim7_r <= lim6_r;
      pa7_r <= pa6_r;
    end
  end

  // stage 8: classification, square-root operands
  logic signed [DW-1:0] d5, a5, b5, nlim;
  logic                 bad, point;
  gbd_pkg::outcome_t    oc_nxt, oc8_r;
  logic [DW-1:0]        xa8_r, xb8_r;
  logic [ANGLE_BITS-1:0] pa8_r;

  assign d5 = (dmt7_r <<< 2) + dmt7_r;
  assign a5 = (ta7_r <<< 2) + ta7_r;
  assign b5 = (tb7_r <<< 2) + tb7_r;
  assign nlim = -lim7_r;
  assign bad = ta7_r[DW-1] || tb7_r[DW-1] || dmt7_r[DW-1];
  assign point = (d5 < lim7_r) && (a5 > nlim) && (b5 > nlim);

  always_comb begin
    if (!bad) begin
      oc_nxt = gbd_pkg::OUTCOME_RESOLVED;
    end else if (point) begin
      oc_nxt = gbd_pkg::OUTCOME_POINT;
    end else begin
      oc_nxt = gbd_pkg::OUTCOME_FAIL;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oc8_r <= oc_nxt;
      xa8_r <= spt7_r[DW-1] ? '0 : ({spt7_r[DW-4:0], 3'b000} << XL);
      xb8_r <= dmt7_r[DW-1] ? '0 : ({dmt7_r[DW-4:0], 3'b000} << XL);
      pa8_r <= pa7_r;
    end
  end

  // square-root chains
  logic [DW-1:0]         qan [0:NQ];
  logic [DW-1:0]         qar [0:NQ];
  logic [1:0]            qat [0:NQ];
  logic [DW-1:0]         qbn [0:NQ];
  logic [DW-1:0]         qbr [0:NQ];
  logic [ANGLE_BITS-1:0] qbt [0:NQ];

  assign qan[0] = xa8_r;
  assign qar[0] = '0;
  assign qat[0] = oc8_r;
  assign qbn[0] = xb8_r;
  assign qbr[0] = '0;
  assign qbt[0] = pa8_r;

  for (genvar k = 0; k < NQ; k++) begin : g_sqrt
    gbd_isqrt_stage #(.IDX(k), .TW(2)) u_maj (
      .clk(clk), .en(en), .n_i(qan[k]), .r_i(qar[k]), .tag_i(qat[k]),
      .n_o(qan[k+1]), .r_o(qar[k+1]), .tag_o(qat[k+1])
    );
    gbd_isqrt_stage #(.IDX(k), .TW(ANGLE_BITS)) u_min (
      .clk(clk), .en(en), .n_i(qbn[k]), .r_i(qbr[k]), .tag_i(qbt[k]),
      .n_o(qbn[k+1]), .r_o(qbr[k+1]), .tag_o(qbt[k+1])
    );
  end

  // output stage: rounding, saturation, selection
  logic [32:0]             ra, rb;
  logic [SIZE_BITS-1:0]    ra_sat, rb_sat;
  logic signed [ANGLE_BITS:0] bfold;
  gbd_pkg::out_item_t      out_data_nxt, out_data_r;

  always_comb begin
    if (E >= 1) begin
      ra = (33'(qar[NQ][31:0]) + (33'd1 << EM1)) >> EL;
      rb = (33'(qbr[NQ][31:0]) + (33'd1 << EM1)) >> EL;
    end else begin
      ra = 33'(qar[NQ][31:0]);
      rb = 33'(qbr[NQ][31:0]);
    end
    ra_sat = (ra > SIZE_MAX) ? SIZE_MAX[SIZE_BITS-1:0] : ra[SIZE_BITS-1:0];
    rb_sat = (rb > SIZE_MAX) ? SIZE_MAX[SIZE_BITS-1:0] : rb[SIZE_BITS-1:0];

    bfold = (ANGLE_BITS + 1)'($signed(beam_angle_r));
    if (bfold > QTR) begin
      bfold = bfold - HALF;
    end else if (bfold <= -QTR) begin
      bfold = bfold + HALF;
    end

    case (gbd_pkg::outcome_t'(qat[NQ]))
      gbd_pkg::OUTCOME_RESOLVED: begin
        out_data_nxt.result_major = ra_sat;
        out_data_nxt.result_minor = rb_sat;
        out_data_nxt.result_angle = qbt[NQ];
        out_data_nxt.outcome = gbd_pkg::OUTCOME_RESOLVED;
      end
      gbd_pkg::OUTCOME_POINT: begin
        out_data_nxt.result_major = beam_major_r;
        out_data_nxt.result_minor = beam_minor_r;
        out_data_nxt.result_angle = bfold[ANGLE_BITS-1:0];
        out_data_nxt.outcome = gbd_pkg::OUTCOME_POINT;
      end
      default: begin
        out_data_nxt.result_major = '0;
        out_data_nxt.result_minor = '0;
        out_data_nxt.result_angle = '0;
        out_data_nxt.outcome = gbd_pkg::OUTCOME_FAIL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_data = out_data_r;

endmodule

### rtl/gbd_checker.sv
module gbd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input gbd_pkg::out_item_t out_data
);

  localparam logic signed [gbd_pkg::ANGLE_BITS-1:0] QTR =
    gbd_pkg::ANGLE_BITS'(1) << (gbd_pkg::ANGLE_BITS - 2);

  a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not track the output stage");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outcome == gbd_pkg::OUTCOME_FAIL |->
      out_data.result_major == '0 && out_data.result_minor == '0 &&
      out_data.result_angle == '0)
    else $error("failure result carries nonzero fields");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.result_angle <= QTR && out_data.result_angle > -QTR)
    else $error("result angle outside half pi range");

endmodule

bind gaussian_beam_deconvolver_unit gbd_checker u_gbd_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data(out_data)
);

### test/tb.sv
module tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 150;
  localparam int SIZE_BITS = gbd_pkg::SIZE_BITS;
  localparam int ANGLE_BITS = gbd_pkg::ANGLE_BITS;
  localparam int CFG_DATA_BITS = gbd_pkg::CFG_DATA_BITS;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  gbd_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  gbd_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [gbd_pkg::CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  gaussian_beam_deconvolver_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // beam as the block should hold it
  logic [SIZE_BITS-1:0] beam_maj = 1;
  logic [SIZE_BITS-1:0] beam_min = 1;
  logic [ANGLE_BITS-1:0] beam_ang = 0;

  gbd_pkg::out_item_t deconv_q[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  function automatic longint sq_fx(longint unsigned a);
    return longint'((a * a) << 8);
  endfunction

  function automatic longint gain_mul(longint v, longint unsigned k);
    longint unsigned mag, r;
    mag = (v < 0) ? longint'(0) - v : v;
    r = (mag >> 30) * k + (((mag & 64'h3FFF_FFFF) * k) >> 30);
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic logic [SIZE_BITS-1:0] axis_len(longint w);
    longint unsigned x, r;
    x = (w < 0) ? 64'd0 : longint'(w) * 8;
    r = (int_sqrt(x) + 32) >> 6;
    return (r > 64'hFF_FFFF) ? 24'hFF_FFFF : r[SIZE_BITS-1:0];
  endfunction

  function automatic void cordic_rot(input longint d, input logic [31:0] u,
                                     output longint ox, output longint oy);
    longint x, y, z, xs, ys;
    logic [31:0] chk;
    x = d;
    y = 0;
    chk = u + 32'h4000_0000;
    if (chk >= 32'h8000_0000) begin
      x = -d;
      u = u + 32'h8000_0000;
    end
    z = longint'($signed(u));
    for (int i = 0; i < gbd_pkg::CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(gbd_pkg::ATAN_TURNS[i]);
      end else begin
        x += ys; y -= xs; z += longint'(gbd_pkg::ATAN_TURNS[i]);
      end
    end
    ox = x;
    oy = y;
  endfunction

  function automatic void cordic_vec(input longint x, input longint y,
                                     output longint mag, output logic [31:0] ang);
    longint z, xs, ys;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = 64'h8000_0000;
    end
    for (int i = 0; i < gbd_pkg::CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += longint'(gbd_pkg::ATAN_TURNS[i]);
      end else begin
        x -= ys; y += xs; z -= longint'(gbd_pkg::ATAN_TURNS[i]);
      end
    end
    mag = x;
    ang = z[31:0];
  endfunction

  function automatic gbd_pkg::out_item_t deconvolve(gbd_pkg::in_item_t d);
    gbd_pkg::out_item_t r;
    longint as2, bs2, ab2, bb2, s, lim, xs, ys, xb, yb, vx, vy, t, cx, two_a, two_b, pa;
    longint mag, zs, b;
    logic [31:0] ang;
    logic [SIZE_BITS-1:0] m;
    as2 = sq_fx(d.source_major);
    bs2 = sq_fx(d.source_minor);
    ab2 = sq_fx(beam_maj);
    bb2 = sq_fx(beam_min);
    s = (as2 + bs2) - (ab2 + bb2);
    m = d.source_major;
    if (d.source_minor < m) m = d.source_minor;
    if (beam_maj < m) m = beam_maj;
    if (beam_min < m) m = beam_min;
    lim = sq_fx(m);
    cordic_rot(as2 - bs2, {d.source_angle[ANGLE_BITS-2:0], 17'b0}, xs, ys);
    cordic_rot(ab2 - bb2, {beam_ang[ANGLE_BITS-2:0], 17'b0}, xb, yb);
    vx = xs - xb;
    vy = ys - yb;
    t = 0;
    pa = 0;
    if (vx != 0 || vy != 0) begin
      cordic_vec(vx, vy, mag, ang);
      t = gain_mul(mag, gbd_pkg::K2_Q30);
      zs = longint'($signed(ang));
      pa = (zs + 65536) >>> 17;
      if (pa == -16384) pa = 16384;
    end
    cx = gain_mul(vx, gbd_pkg::K_Q30);
    two_a = s + cx;
    two_b = s - cx;
    if (two_a < 0 || two_b < 0 || s < t) begin
      if (5 * (s - t) < lim && 5 * two_a > -lim && 5 * two_b > -lim) begin
        b = longint'($signed(beam_ang));
        if (b > 16384) b -= 32768;
        else if (b <= -16384) b += 32768;
        r.result_major = beam_maj;
        r.result_minor = beam_min;
        r.result_angle = b[ANGLE_BITS-1:0];
        r.outcome = gbd_pkg::OUTCOME_POINT;
      end else begin
        r = '0;
        r.outcome = gbd_pkg::OUTCOME_FAIL;
      end
    end else begin
      r.result_major = axis_len(s + t);
      r.result_minor = axis_len(s - t);
      r.result_angle = pa[ANGLE_BITS-1:0];
      r.outcome = gbd_pkg::OUTCOME_RESOLVED;
    end
    return r;
  endfunction

  task automatic send_source(gbd_pkg::in_item_t d, bit typed, gbd_pkg::out_item_t e);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
    deconv_q.push_back(typed ? e : deconvolve(d));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (deconv_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_beam(gbd_pkg::cfg_addr_t a, logic [CFG_DATA_BITS-1:0] v);
    cfg_valid <= 1'b1;
    cfg_addr <= a;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (a)
      gbd_pkg::CFG_BEAM_MAJOR: beam_maj = v[SIZE_BITS-1:0];
      gbd_pkg::CFG_BEAM_MINOR: beam_min = v[SIZE_BITS-1:0];
      gbd_pkg::CFG_BEAM_ANGLE: beam_ang = v[ANGLE_BITS-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [SIZE_BITS-1:0] clamp_size(longint v);
    if (v < 0) return '0;
    if (v > 64'hFF_FFFF) return 24'hFF_FFFF;
    return v[SIZE_BITS-1:0];
  endfunction

  function automatic gbd_pkg::in_item_t rand_source();
    gbd_pkg::in_item_t d;
    longint span;
    d.source_angle = $urandom;
    case ($urandom_range(3))
      0: begin
        d.source_major = $urandom;
        d.source_minor = $urandom;
      end
      1: begin
        span = beam_maj / 8 + 2;
        d.source_major = clamp_size(beam_maj + $urandom_range(span) - span / 2);
        d.source_minor = clamp_size(beam_min + $urandom_range(span) - span / 2);
        if ($urandom_range(1)) d.source_angle = beam_ang + $urandom_range(512) - 256;
      end
      2: begin
        d.source_major = clamp_size(beam_maj + longint'(beam_maj) * $urandom_range(40) / 8
                                    + $urandom_range(1000));
        d.source_minor = clamp_size(beam_maj + longint'(beam_min) * $urandom_range(40) / 8
                                    + $urandom_range(1000));
      end
      default: begin
        d.source_major = $urandom_range(4095);
        d.source_minor = $urandom_range(4095);
      end
    endcase
    return d;
  endfunction

  typedef struct {
    gbd_pkg::in_item_t  d;
    bit                 typed;
    gbd_pkg::out_item_t e;
  } stim_row_t;

  stim_row_t directed [13] = '{
    '{'{24'd0, 24'd0, 16'sd0}, 1'b1, '{24'd0, 24'd0, 16'sd0, gbd_pkg::OUTCOME_FAIL}},
    '{'{24'd1, 24'd1, 16'sd0}, 1'b1, '{24'd0, 24'd0, 16'sd0, gbd_pkg::OUTCOME_RESOLVED}},
    '{'{24'hFF_FFFF, 24'hFF_FFFF, 16'sd0}, 1'b0, '0},
    '{'{24'hFF_FFFF, 24'd0, -16'sd32768}, 1'b0, '0},
    '{'{24'hFF_FFFF, 24'd1, 16'sd32767}, 1'b0, '0},
    '{'{24'd1000, 24'd500, 16'sd16384}, 1'b0, '0},
    '{'{24'd1000, 24'd500, -16'sd16384}, 1'b0, '0},
    '{'{24'd500, 24'd1000, 16'sd8192}, 1'b0, '0},
    '{'{24'd0, 24'hFF_FFFF, -16'sd1}, 1'b0, '0},
    '{'{24'h80_0000, 24'h7F_FFFF, 16'sh5555}, 1'b0, '0},
    '{'{24'd2, 24'd1, 16'sd0}, 1'b0, '0},
    '{'{24'd1, 24'd0, 16'sd100}, 1'b0, '0},
    '{'{24'h55_5555, 24'h2A_AAAA, -16'sh2AAB}, 1'b0, '0}
  };

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_source(directed[i].d, directed[i].typed, directed[i].e);
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          write_beam(gbd_pkg::CFG_BEAM_MAJOR, 24'd1);
          write_beam(gbd_pkg::CFG_BEAM_MINOR, 24'd1);
          write_beam(gbd_pkg::CFG_BEAM_ANGLE, 24'h00_8000);
          idle_pct = 0; stall_pct = 0;
        end
        1: begin
          write_beam(gbd_pkg::CFG_BEAM_MAJOR, 24'hFF_FFFF);
          write_beam(gbd_pkg::CFG_BEAM_MINOR, 24'hFF_FFFF);
          write_beam(gbd_pkg::CFG_BEAM_ANGLE, 24'h00_7FFF);
          idle_pct = 80; stall_pct = 0;
        end
        2: begin
          write_beam(gbd_pkg::CFG_BEAM_MAJOR, 24'd3000);
          write_beam(gbd_pkg::CFG_BEAM_MINOR, 24'd1200);
          write_beam(gbd_pkg::CFG_BEAM_ANGLE, 24'h00_1234);
          idle_pct = 0; stall_pct = 80;
        end
        default: begin
          write_beam(gbd_pkg::CFG_BEAM_MAJOR, CFG_DATA_BITS'($urandom_range(24'hFF_FFFF, 1)));
          write_beam(gbd_pkg::CFG_BEAM_MINOR, CFG_DATA_BITS'($urandom_range(24'hFF_FFFF, 1)));
          write_beam(gbd_pkg::CFG_BEAM_ANGLE, CFG_DATA_BITS'($urandom_range(16'hFFFF)));
          idle_pct = 31; stall_pct = 31;
        end
      endcase
      repeat (100) send_source(rand_source(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (deconv_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
          || deconv_q.size() == 0)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (deconv_q.size() == 0) begin
          $error("unexpected transfer on out");
          errors++;
        end else begin
          gbd_pkg::out_item_t e;
          e = deconv_q.pop_front();
          if (out_data.result_major !== e.result_major) begin
            $error("result_major exp %0d got %0d", e.result_major, out_data.result_major);
            errors++;
          end
          if (out_data.result_minor !== e.result_minor) begin
            $error("result_minor exp %0d got %0d", e.result_minor, out_data.result_minor);
            errors++;
          end
          if (out_data.result_angle !== e.result_angle) begin
            $error("result_angle exp %0d got %0d", e.result_angle, out_data.result_angle);
            errors++;
          end
          if (out_data.outcome !== e.outcome) begin
            $error("outcome exp %0d got %0d", e.outcome, out_data.outcome);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

endmodule
